// ===== hdl/hft_pkg.sv =====
// Shared types, constants and helper functions of the heterodyne frequency tracker.
// No dependencies; imported by hdl/heterodyne_frequency_tracker.sv and tb/tb.sv.
package hft_pkg;

	localparam int SAMPLE_W = 16;
	localparam int PHASE_W  = 16;
	localparam int FILT_W   = 24;
	localparam int FFRAC    = FILT_W - 2;
	localparam int STEPS    = 16;
	localparam int CNT_W    = 4;
	localparam int POW_W    = 17;
	localparam int ADDR_W   = 5;

	localparam logic signed [32:0] CK_Q30 = 33'sd652032874;
	localparam logic signed [16:0] POW_MAX = 17'sd65535;

	localparam logic [2:0] REG_INIT_FREQ = 3'd0;
	localparam logic [2:0] REG_POLE      = 3'd1;
	localparam logic [2:0] REG_SMOOTH    = 3'd2;
	localparam logic [2:0] REG_GAIN      = 3'd3;
	localparam logic [2:0] REG_THRESH    = 3'd4;

	typedef enum logic [4:0] {
		S_IDLE, S_ROT, S_MRE, S_MIM, S_FRE1, S_FRE2, S_FIM1, S_FIM2,
		S_VF_INIT, S_VF, S_MAG1, S_MAG2, S_POW1, S_POW2, S_POW3, S_CHK,
		S_VR_INIT, S_VR, S_DEL1, S_DEL2, S_ADV, S_DONE
	} hft_state_t;

	// Arctangent of 2^-i, a full turn being 2^32.
	function automatic logic [31:0] hft_atan(input logic [CNT_W-1:0] i);
		logic [31:0] r;
		case (i)
			4'd0:    r = 32'h20000000;
			4'd1:    r = 32'h12E4051E;
			4'd2:    r = 32'h09FB385B;
			4'd3:    r = 32'h051111D4;
			4'd4:    r = 32'h028B0D43;
			4'd5:    r = 32'h0145D7E1;
			4'd6:    r = 32'h00A2F61E;
			4'd7:    r = 32'h00517C55;
			4'd8:    r = 32'h0028BE53;
			4'd9:    r = 32'h00145F2F;
			4'd10:   r = 32'h000A2F98;
			4'd11:   r = 32'h000517CC;
			4'd12:   r = 32'h00028BE6;
			4'd13:   r = 32'h000145F3;
			4'd14:   r = 32'h0000A2FA;
			4'd15:   r = 32'h0000517D;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

	// Saturate a wide signed value to the filter format.
	function automatic logic signed [FILT_W-1:0] hft_sat(input logic signed [65:0] v);
		logic signed [65:0] hi;
		logic signed [65:0] lo;
		hi = (66'sd1 <<< (FILT_W - 1)) - 66'sd1;
		lo = -hi - 66'sd1;
		if (v > hi) begin
			return hi[FILT_W-1:0];
		end else if (v < lo) begin
			return lo[FILT_W-1:0];
		end
		return v[FILT_W-1:0];
	endfunction

endpackage

// ===== hdl/heterodyne_frequency_tracker.sv =====
// Heterodyne frequency tracker: mixer, complex low-pass, power smoother and
// frequency loop built around one shared CORDIC unit and one shared multiplier.
// Depends on hdl/hft_pkg.sv.

// One beat in gives one beat out. The shared CORDIC unit runs 16 rotation steps
// for the oscillator and 16 vectoring steps for the filtered angle and magnitude.
// The vectoring pass is skipped when the filtered value is zero. When the power
// estimate is at or above power_threshold, it runs 16 more vectoring steps for
// the reference angle, and these are skipped when the reference is zero. The
// shared multiplier serves the steps for mixing, filtering, magnitude scaling,
// power smoothing and the frequency correction. sample_stall is high from the
// accepted beat until its result is loaded into the output register. That
// register holds the result until result_stall drops, so one finished result
// can wait while the next sample is already in work. A restart beat reloads the
// tracker state (phase zero, frequency from initial_frequency, filter cleared,
// reference at one, power zero) and keeps the registers. Registers sit at byte
// addresses 0, 4, 8, 12 and 16 in the order initial_frequency, filter_pole,
// power_smoothing, frequency_gain, power_threshold; write them only while the
// block is idle.
module heterodyne_frequency_tracker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [hft_pkg::ADDR_W-1:0]         paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	input  logic                               sample_valid,
	output logic                               sample_stall,
	input  logic signed [hft_pkg::SAMPLE_W-1:0] sample,
	input  logic                               restart,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic [15:0]                        power,
	output logic signed [hft_pkg::PHASE_W-1:0] phase,
	output logic signed [hft_pkg::PHASE_W-1:0] frequency
);
	import hft_pkg::*;

	// Configuration registers.
	logic [15:0] init_freq_q, pole_q, smooth_q, gain_q, thresh_q;

	// Tracker state.
	logic [PHASE_W-1:0]       phase_q, freq_q;
	logic signed [FILT_W-1:0] filt_re_q, filt_im_q, ref_re_q, ref_im_q;
	logic [POW_W-1:0]         pacc_q;

	// Working registers.
	hft_state_t                state_q, state_d;
	logic signed [SAMPLE_W-1:0] smp_q;
	logic signed [63:0]        x_q, y_q;
	logic [31:0]               z_q, af_q;
	logic [CNT_W-1:0]          cnt_q;
	logic signed [25:0]        hre_q, him_q;
	logic [POW_W-1:0]          mag_q;
	logic signed [65:0]        prod_q, acc_q;
	logic                      rvalid_q;
	logic [15:0]               power_q;
	logic [PHASE_W-1:0]        phase_out_q, freq_out_q;

	// Shared multiplier operands.
	logic signed [32:0] mul_a, mul_b;
	logic               rot_mode;

	// New imaginary filter output, ready in the step after its last product.
	logic signed [FILT_W-1:0] fim_new;

	logic accept, cfg_wr, iter_last, out_free;
	assign accept    = sample_valid && !sample_stall;
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign iter_last = (cnt_q == CNT_W'(STEPS - 1));
	assign out_free  = !rvalid_q || !result_stall;

	assign pready       = 1'b1;
	assign sample_stall = (state_q != S_IDLE);
	assign result_valid = rvalid_q;
	assign power        = power_q;
	assign phase        = phase_out_q;
	assign frequency    = freq_out_q;

	always_comb begin
		case (paddr[4:2])
			REG_INIT_FREQ: prdata = {16'd0, init_freq_q};
			REG_POLE:      prdata = {16'd0, pole_q};
			REG_SMOOTH:    prdata = {16'd0, smooth_q};
			REG_GAIN:      prdata = {16'd0, gain_q};
			REG_THRESH:    prdata = {16'd0, thresh_q};
			default:       prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_freq_q <= 16'd0;
			pole_q      <= 16'd62259;
			smooth_q    <= 16'd62259;
			gain_q      <= 16'd655;
			thresh_q    <= 16'd0;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_INIT_FREQ: init_freq_q <= pwdata[15:0];
				REG_POLE:      pole_q      <= pwdata[15:0];
				REG_SMOOTH:    smooth_q    <= pwdata[15:0];
				REG_GAIN:      gain_q      <= pwdata[15:0];
				REG_THRESH:    thresh_q    <= pwdata[15:0];
				default:       ;
			endcase
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:    if (accept) state_d = S_ROT;
			S_ROT:     if (iter_last) state_d = S_MRE;
			S_MRE:     state_d = S_MIM;
			S_MIM:     state_d = S_FRE1;
			S_FRE1:    state_d = S_FRE2;
			S_FRE2:    state_d = S_FIM1;
			S_FIM1:    state_d = S_FIM2;
			S_FIM2:    state_d = S_VF_INIT;
			S_VF_INIT: state_d = (filt_re_q == '0 && fim_new == '0) ? S_MAG1 : S_VF;
			S_VF:      if (iter_last) state_d = S_MAG1;
			S_MAG1:    state_d = S_MAG2;
			S_MAG2:    state_d = S_POW1;
			S_POW1:    state_d = S_POW2;
			S_POW2:    state_d = S_POW3;
			S_POW3:    state_d = S_CHK;
			S_CHK:     state_d = (pacc_q >= POW_W'(thresh_q)) ? S_VR_INIT : S_ADV;
			S_VR_INIT: state_d = (ref_re_q == '0 && ref_im_q == '0) ? S_DEL1 : S_VR;
			S_VR:      if (iter_last) state_d = S_DEL1;
			S_DEL1:    state_d = S_DEL2;
			S_DEL2:    state_d = S_ADV;
			S_ADV:     state_d = S_DONE;
			S_DONE:    if (out_free) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// Multiplier operand selection and CORDIC mode.
	always_comb begin
		mul_a    = '0;
		mul_b    = '0;
		rot_mode = (state_q == S_ROT);
		case (state_q)
			S_MRE: begin
				mul_a = 33'(smp_q);
				mul_b = x_q[32:0];
			end
			S_MIM: begin
				mul_a = 33'(smp_q);
				mul_b = y_q[32:0];
			end
			S_FRE1: begin
				mul_a = 33'sd65536 - $signed({17'd0, pole_q});
				mul_b = 33'(hre_q);
			end
			S_FRE2: begin
				mul_a = $signed({17'd0, pole_q});
				mul_b = 33'(filt_re_q);
			end
			S_FIM1: begin
				mul_a = 33'sd65536 - $signed({17'd0, pole_q});
				mul_b = 33'(him_q);
			end
			S_FIM2: begin
				mul_a = $signed({17'd0, pole_q});
				mul_b = 33'(filt_im_q);
			end
			S_MAG1: begin
				mul_a = 33'(x_q >>> 36);
				mul_b = CK_Q30;
			end
			S_POW1: begin
				mul_a = 33'sd65536 - $signed({17'd0, smooth_q});
				mul_b = $signed({16'd0, mag_q});
			end
			S_POW2: begin
				mul_a = $signed({17'd0, smooth_q});
				mul_b = $signed({16'd0, pacc_q});
			end
			S_DEL1: begin
				mul_a = 33'($signed(af_q - z_q));
				mul_b = $signed({17'd0, gain_q});
			end
			default: ;
		endcase
	end

	// CORDIC step.
	logic signed [63:0] xs, ys, x_n, y_n;
	logic [31:0]        z_n, atan_i;
	logic               dir_neg;
	always_comb begin
		xs      = x_q >>> cnt_q;
		ys      = y_q >>> cnt_q;
		atan_i  = hft_atan(cnt_q);
		dir_neg = rot_mode ? !z_q[31] : y_q[63];
		if (dir_neg) begin
			x_n = x_q - ys;
			y_n = y_q + xs;
			z_n = z_q - atan_i;
		end else begin
			x_n = x_q + ys;
			y_n = y_q - xs;
			z_n = z_q + atan_i;
		end
	end

	// Derived values for the arithmetic steps.
	logic signed [65:0] hre_w, him_w, fsum, fsh, m1, m2, psum, dsum;
	logic [31:0]        z_start;
	logic               wrap;
	logic signed [63:0] vx, vy;
	logic [PHASE_W-1:0] phase_start;
	always_comb begin
		hre_w = (prod_q + (66'sd1 <<< 22)) >>> 23;
		him_w = (-prod_q + (66'sd1 <<< 22)) >>> 23;
		fsum  = acc_q + prod_q + 66'sd32768;
		fsh   = fsum >>> 16;
		m1    = (prod_q + (66'sd1 <<< 29)) >>> 30;
		m2    = (m1 + 66'sd64) >>> 7;
		psum  = (acc_q + prod_q + 66'sd32768) >>> 16;
		dsum  = (prod_q + (66'sd1 <<< 31)) >>> 32;
		phase_start = restart ? '0 : phase_q;
		z_start = {phase_start, 16'd0};
		wrap  = ($signed(z_start) > 32'sh40000000) || ($signed(z_start) < -32'sh40000000);
		if (state_q == S_VF_INIT) begin
			vx = 64'(filt_re_q) <<< 36;
			vy = 64'(fim_new) <<< 36;
		end else begin
			vx = 64'(ref_re_q) <<< 36;
			vy = 64'(ref_im_q) <<< 36;
		end
	end

	assign fim_new = hft_sat(fsh);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			rvalid_q  <= 1'b0;
			phase_q   <= '0;
			freq_q    <= '0;
			filt_re_q <= '0;
			filt_im_q <= '0;
			ref_re_q  <= FILT_W'(1) <<< FFRAC;
			ref_im_q  <= '0;
			pacc_q    <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DONE && out_free) rvalid_q <= 1'b1;
			else if (!result_stall) rvalid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (accept && restart) begin
					phase_q   <= '0;
					freq_q    <= init_freq_q[PHASE_W-1:0];
					filt_re_q <= '0;
					filt_im_q <= '0;
					ref_re_q  <= FILT_W'(1) <<< FFRAC;
					ref_im_q  <= '0;
					pacc_q    <= '0;
				end
				S_ROT, S_VF, S_VR: cnt_q <= cnt_q + 1'b1;
				S_FIM1:  filt_re_q <= hft_sat(fsh);
				S_VF_INIT: begin
					filt_im_q <= fim_new;
					cnt_q     <= '0;
				end
				S_VR_INIT: cnt_q <= '0;
				S_POW3: begin
					if (psum > 66'sd131071) pacc_q <= '1;
					else pacc_q <= psum[POW_W-1:0];
				end
				S_DEL2: begin
					freq_q   <= freq_q + dsum[PHASE_W-1:0];
					ref_re_q <= filt_re_q;
					ref_im_q <= filt_im_q;
				end
				S_ADV: phase_q <= phase_q + freq_q;
				default: ;
			endcase
		end
	end

	// Payload registers: no reset.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			S_IDLE: if (accept) begin
				smp_q <= sample;
				x_q   <= wrap ? -64'(CK_Q30) : 64'(CK_Q30);
				y_q   <= '0;
				z_q   <= wrap ? z_start + 32'h80000000 : z_start;
			end
			S_ROT, S_VF, S_VR: begin
				x_q <= x_n;
				y_q <= y_n;
				z_q <= z_n;
			end
			S_MIM:  hre_q <= hre_w[25:0];
			S_FRE1: him_q <= him_w[25:0];
			S_FRE2, S_FIM2, S_POW2: acc_q <= prod_q;
			S_VF_INIT, S_VR_INIT: begin
				if (vx == 0 && vy == 0) begin
					x_q <= '0;
					y_q <= '0;
					z_q <= '0;
				end else if (vx < 0) begin
					x_q <= -vx;
					y_q <= -vy;
					z_q <= 32'h80000000;
				end else begin
					x_q <= vx;
					y_q <= vy;
					z_q <= '0;
				end
			end
			S_MAG1: af_q <= z_q;
			S_MAG2: begin
				if (m2 < 0) mag_q <= '0;
				else if (m2 > 66'sd131071) mag_q <= '1;
				else mag_q <= m2[POW_W-1:0];
			end
			S_DONE: if (out_free) begin
				power_q     <= (pacc_q > POW_W'(POW_MAX)) ? 16'hFFFF : pacc_q[15:0];
				phase_out_q <= phase_q;
				freq_out_q  <= freq_q;
			end
			default: ;
		endcase
	end

	// Assertions.
	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> sample_stall)
		else $error("sample accepted while busy");
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_ROT && cnt_q == '0))
		else $error("accepted beat did not start the oscillator pass");
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q) == S_DONE)
		else $error("result raised outside the final step");
	a_vec_starts_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_VF || state_q == S_VR) && $past(state_q) != state_q |-> cnt_q == '0)
		else $error("vectoring pass started with a stale step count");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the heterodyne frequency tracker.
// Depends on hdl/hft_pkg.sv and hdl/heterodyne_frequency_tracker.sv.
// Beats are predicted by a bit-exact fixed-point tracker model held in this module.
module tb;
	import hft_pkg::*;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic sample_valid, sample_stall, restart;
	logic signed [SAMPLE_W-1:0] sample;
	logic result_valid, result_stall;
	logic [15:0] power;
	logic signed [PHASE_W-1:0] phase, frequency;

	heterodyne_frequency_tracker u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.sample_valid(sample_valid), .sample_stall(sample_stall),
		.sample(sample), .restart(restart),
		.result_valid(result_valid), .result_stall(result_stall),
		.power(power), .phase(phase), .frequency(frequency)
	);

	// One result beat: the three output fields.
	typedef struct packed {
		logic [15:0] pwr;
		logic [15:0] ph;
		logic [15:0] frq;
	} track_out_t;

	// One row of the directed table. When known is set the expected result is
	// typed in the row; otherwise the tracker model supplies it.
	typedef struct {
		logic signed [15:0] smp;
		logic               rst;
		logic               known;
		track_out_t         res;
	} stim_row_t;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 100;
	localparam int LONG_HOLD      = 300;

	// Arctangent of 2^-i in 2^32 units per turn.
	localparam logic [31:0] ATAN [16] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
	};

	// Register copies and tracker state used for prediction.
	logic [15:0] cfg_init_freq, cfg_pole, cfg_smooth, cfg_gain, cfg_thresh;
	logic [15:0] trk_phase, trk_freq;
	longint      trk_fre, trk_fim, trk_rre, trk_rim;
	longint      trk_pow;

	track_out_t pending_results[$];
	int         mismatches;
	int         beats_in, beats_out;
	int         idle_cycles;
	bit         no_gaps;
	bit         long_hold_req;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Reload the tracker state, as reset and the restart flag do.
	function automatic void reload_tracker();
		trk_phase = '0;
		trk_freq  = cfg_init_freq;
		trk_fre   = 0;
		trk_fim   = 0;
		trk_rre   = longint'(1) <<< FFRAC;
		trk_rim   = 0;
		trk_pow   = 0;
	endfunction

	function automatic longint sat_filt(input longint v);
		longint hi;
		hi = (longint'(1) <<< (FILT_W - 1)) - 1;
		if (v > hi) begin
			return hi;
		end
		if (v < -hi - 1) begin
			return -hi - 1;
		end
		return v;
	endfunction

	// CORDIC rotation: cosine and sine in Q30 of a 32-bit angle.
	function automatic void osc_cos_sin(input logic [31:0] ang, output longint c,
			output longint s);
		longint x, y, t;
		logic [31:0] z;
		x = CK_Q30;
		y = 0;
		z = ang;
		if ($signed(z) > 32'sh40000000 || $signed(z) < -32'sh40000000) begin
			x = -x;
			z = z + 32'h80000000;
		end
		for (int i = 0; i < STEPS; i++) begin
			if (!z[31]) begin
				t = x - (y >>> i); y = y + (x >>> i); z = z - ATAN[i];
			end else begin
				t = x + (y >>> i); y = y - (x >>> i); z = z + ATAN[i];
			end
			x = t;
		end
		c = x;
		s = y;
	endfunction

	// CORDIC vectoring: angle in 2^32 units and gain-scaled radius.
	function automatic logic [31:0] vec_angle(input longint vx, input longint vy,
			output longint rad);
		longint x, y, t;
		logic [31:0] z;
		z = '0;
		if (vx == 0 && vy == 0) begin
			rad = 0;
			return '0;
		end
		x = vx * (longint'(1) <<< (60 - FILT_W));
		y = vy * (longint'(1) <<< (60 - FILT_W));
		if (x < 0) begin
			x = -x; y = -y; z = 32'h80000000;
		end
		for (int i = 0; i < STEPS; i++) begin
			if (y < 0) begin
				t = x - (y >>> i); y = y + (x >>> i); z = z - ATAN[i];
			end else begin
				t = x + (y >>> i); y = y - (x >>> i); z = z + ATAN[i];
			end
			x = t;
		end
		rad = x;
		return z;
	endfunction

	// Advance the tracker by one sample and return the result it produces.
	function automatic track_out_t track_sample(input logic signed [15:0] smp,
			input logic rst);
		longint c, s, hre, him, rad, mag, d, delta, b0, sv;
		logic [31:0] ang_f, ang_r, diff;
		track_out_t r;
		if (rst) begin
			reload_tracker();
		end
		sv = smp;
		b0 = 65536 - longint'(cfg_pole);
		osc_cos_sin({trk_phase, 16'h0}, c, s);
		hre = (sv * c + (longint'(1) <<< 22)) >>> 23;
		him = (-(sv * s) + (longint'(1) <<< 22)) >>> 23;
		trk_fre = sat_filt((b0 * hre + longint'(cfg_pole) * trk_fre + 32768) >>> 16);
		trk_fim = sat_filt((b0 * him + longint'(cfg_pole) * trk_fim + 32768) >>> 16);
		ang_f = vec_angle(trk_fre, trk_fim, rad);
		mag = ((rad >>> (60 - FILT_W)) * CK_Q30 + (longint'(1) <<< 29)) >>> 30;
		mag = (mag + 64) >>> 7;
		if (mag < 0) mag = 0;
		if (mag > 131071) mag = 131071;
		d = (65536 - longint'(cfg_smooth)) * mag + longint'(cfg_smooth) * trk_pow + 32768;
		d = d >>> 16;
		if (d > 131071) d = 131071;
		trk_pow = d;
		if (trk_pow >= longint'(cfg_thresh)) begin
			ang_r = vec_angle(trk_rre, trk_rim, rad);
			diff  = ang_f - ang_r;
			delta = (longint'($signed(diff)) * longint'(cfg_gain)
				+ (longint'(1) <<< 31)) >>> 32;
			trk_freq = trk_freq + delta[15:0];
			trk_rre = trk_fre;
			trk_rim = trk_fim;
		end
		trk_phase = trk_phase + trk_freq;
		r.pwr = (trk_pow > 65535) ? 16'hFFFF : trk_pow[15:0];
		r.ph  = trk_phase;
		r.frq = trk_freq;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		$display("mismatch on result %0d: %s got %0d expected %0d", beats_out, what,
			got, want);
		mismatches++;
	endtask

	// Register write over the configuration port: setup cycle, then access cycle.
	task automatic write_reg(input int idx, input logic [31:0] val);
		@(negedge clk);
		psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
		paddr = ADDR_W'(idx * 4); pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
		case (3'(idx))
			REG_INIT_FREQ: cfg_init_freq = val[15:0];
			REG_POLE:      cfg_pole      = val[15:0];
			REG_SMOOTH:    cfg_smooth    = val[15:0];
			REG_GAIN:      cfg_gain      = val[15:0];
			REG_THRESH:    cfg_thresh    = val[15:0];
			default: ;
		endcase
	endtask

	// Wait until every predicted result has come back, then let any work that
	// is still in flight settle.
	task automatic drain_results();
		wait (pending_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Offer one sample beat, after a random gap unless no_gaps is set; predict once it is taken.
	task automatic send_beat(input logic signed [15:0] smp, input logic rst,
			input bit known, input track_out_t typed);
		int gap;
		track_out_t pred;
		gap = no_gaps ? 0 : $urandom_range(0, 12);
		repeat (gap) begin
			@(negedge clk);
			sample_valid = 1'b0;
		end
		@(negedge clk);
		sample_valid = 1'b1;
		sample = smp;
		restart = rst;
		do @(posedge clk); while (sample_stall);
		pred = track_sample(smp, rst);
		pending_results.push_back(known ? typed : pred);
		beats_in++;
	endtask

	task automatic idle_sender();
		@(negedge clk);
		sample_valid = 1'b0;
	endtask

	// A stretch of random traffic: mostly tones with random pitch and level,
	// some wideband noise, and an occasional restart.
	task automatic random_block(input int count);
		int amp, step, ph, kind;
		logic signed [15:0] smp;
		amp = 0; step = 0; ph = 0; kind = 0;
		for (int n = 0; n < count; n++) begin
			if (n % 40 == 0) begin
				kind = $urandom_range(0, 9);
				amp  = $urandom_range(0, 32767);
				step = $urandom_range(0, 65535);
				ph   = $urandom_range(0, 65535);
			end
			if (kind < 7) begin
				smp = 16'($rtoi(amp * $sin(6.283185307179586 * ph / 65536.0)));
				ph  = (ph + step) % 65536;
			end else begin
				smp = 16'($urandom);
			end
			send_beat(smp, ($urandom_range(0, 60) == 0), 1'b0, '0);
		end
	endtask

	// Result side: a random stall before each beat, or one long hold when
	// asked, then stall stays low until a beat is taken.
	initial begin
		int hold;
		result_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold_req) begin
				hold = LONG_HOLD;
				long_hold_req = 1'b0;
			end else begin
				hold = no_gaps ? 0 : $urandom_range(0, 12);
			end
			repeat (hold) begin
				@(negedge clk);
				result_stall = 1'b1;
			end
			@(negedge clk);
			result_stall = 1'b0;
			do @(posedge clk); while (!result_valid);
		end
	end

	// Result checker: every taken beat is compared with the oldest prediction.
	always @(posedge clk) begin
		track_out_t want;
		if (arst_n && result_valid && !result_stall) begin
			beats_out++;
			if (pending_results.size() == 0) begin
				$display("unexpected result beat %0d", beats_out);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (power != want.pwr) report_mismatch("power", power, want.pwr);
				if (phase != want.ph) report_mismatch("phase", phase, want.ph);
				if (frequency != want.frq) report_mismatch("frequency", frequency, want.frq);
			end
		end
	end

	// Watchdog: a long run of cycles with no beat on either side ends the run.
	always @(posedge clk) begin
		if ((sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout after %0d idle cycles", idle_cycles);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	// Directed table. The first beat after reset is all zero: a silent input
	// leaves the filter, the power and the loop untouched.
	stim_row_t directed[] = '{
		'{16'sd0,      1'b0, 1'b1, '{16'd0, 16'd0, 16'd0}},
		'{16'sd32767,  1'b0, 1'b0, '0},
		'{-16'sd32768, 1'b0, 1'b0, '0},
		'{16'sd32767,  1'b0, 1'b0, '0},
		'{-16'sd32768, 1'b0, 1'b0, '0},
		'{16'sd1,      1'b0, 1'b0, '0},
		'{-16'sd1,     1'b0, 1'b0, '0},
		'{16'sd0,      1'b1, 1'b0, '0},
		'{16'sd0,      1'b0, 1'b0, '0},
		'{16'sh5555,   1'b0, 1'b0, '0},
		'{16'shAAAA,   1'b0, 1'b0, '0},
		'{16'sd32767,  1'b1, 1'b0, '0},
		'{16'sd32767,  1'b0, 1'b0, '0},
		'{16'sd32767,  1'b0, 1'b0, '0},
		'{-16'sd32768, 1'b1, 1'b0, '0},
		'{16'sd0,      1'b0, 1'b0, '0}
	};

	initial begin
		idle_cycles = 0;
		mismatches = 0;
		beats_in = 0;
		beats_out = 0;
		no_gaps = 1'b0;
		long_hold_req = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		sample_valid = 1'b0; sample = '0; restart = 1'b0;
		cfg_init_freq = 16'd0; cfg_pole = 16'd62259; cfg_smooth = 16'd62259;
		cfg_gain = 16'd655; cfg_thresh = 16'd0;
		reload_tracker();
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: directed rows, then a first random stretch.
		foreach (directed[k]) begin
			send_beat(directed[k].smp, directed[k].rst, directed[k].known, directed[k].res);
		end
		random_block(100);
		idle_sender();
		drain_results();

		// Extremes: fastest filters, largest gain, top initial frequency, so the
		// tracked frequency wraps around. Upper data bits must be dropped, and a
		// write past the last register must change nothing.
		write_reg(REG_INIT_FREQ, 32'hFFFF_7FFF);
		write_reg(REG_POLE, 32'h0000_0000);
		write_reg(REG_SMOOTH, 32'hABCD_0000);
		write_reg(REG_GAIN, 32'h0000_FFFF);
		write_reg(REG_THRESH, 32'h0000_0000);
		write_reg(5, 32'h0000_1234);
		write_reg(7, 32'hFFFF_FFFF);
		send_beat(16'sd1000, 1'b1, 1'b0, '0);
		no_gaps = 1'b1;
		random_block(100);
		no_gaps = 1'b0;
		idle_sender();
		drain_results();

		// Other extremes: slowest filters, no gain, threshold never reached.
		write_reg(REG_INIT_FREQ, 32'h0000_8000);
		write_reg(REG_POLE, 32'h0000_FFFF);
		write_reg(REG_SMOOTH, 32'h0000_FFFF);
		write_reg(REG_GAIN, 32'h0000_0000);
		write_reg(REG_THRESH, 32'h0000_FFFF);
		send_beat(-16'sd32768, 1'b1, 1'b0, '0);
		random_block(80);
		idle_sender();
		drain_results();

		// A working loop setup. The result side holds off for a long stretch
		// while samples keep coming, so the block backs up; later the sender
		// pauses until every result is back.
		write_reg(REG_INIT_FREQ, 32'h0000_0800);
		write_reg(REG_POLE, 32'd60000);
		write_reg(REG_SMOOTH, 32'd62000);
		write_reg(REG_GAIN, 32'd3000);
		write_reg(REG_THRESH, 32'd200);
		send_beat(16'sd0, 1'b1, 1'b0, '0);
		long_hold_req = 1'b1;
		no_gaps = 1'b1;
		random_block(60);
		no_gaps = 1'b0;
		idle_sender();
		wait (pending_results.size() == 0);
		random_block(100);
		idle_sender();
		drain_results();

		// Random register settings.
		for (int p = 0; p < 4; p++) begin
			write_reg(REG_INIT_FREQ, $urandom);
			write_reg(REG_POLE, $urandom_range(40000, 65535));
			write_reg(REG_SMOOTH, $urandom);
			write_reg(REG_GAIN, $urandom_range(0, 20000));
			write_reg(REG_THRESH, $urandom_range(0, 4000));
			send_beat(16'($urandom), 1'b1, 1'b0, '0);
			random_block(60);
			idle_sender();
			drain_results();
		end

		$display("run covered %0d sample beats and %0d result beats over 8 register settings",
			beats_in, beats_out);
		$display("settings included register extremes, restarts, tones, noise and backpressure");
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches, %0d results never came", mismatches,
				pending_results.size());
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
